/* design/gcb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gcb_pkg;

    // Field widths
    localparam int CLS_W = 4;
    localparam int CJ_W  = 2;

    // Default depth of the front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    // Grapheme break classes; codes above LVT fold to OTHER in the front
    typedef enum logic [CLS_W-1:0] {
        CLS_OTHER   = 4'd0,
        CLS_CR      = 4'd1,
        CLS_LF      = 4'd2,
        CLS_CONTROL = 4'd3,
        CLS_EXTEND  = 4'd4,
        CLS_ZWJ     = 4'd5,
        CLS_RI      = 4'd6,
        CLS_PREPEND = 4'd7,
        CLS_SPACING = 4'd8,
        CLS_L       = 4'd9,
        CLS_V       = 4'd10,
        CLS_T       = 4'd11,
        CLS_LV      = 4'd12,
        CLS_LVT     = 4'd13
    } t_cls;

    // Indic conjunct classes
    typedef enum logic [CJ_W-1:0] {
        CJ_NONE      = 2'd0,
        CJ_LINKER    = 2'd1,
        CJ_CONSONANT = 2'd2,
        CJ_EXTEND    = 2'd3
    } t_cj;

    // Pictograph Extend* ZWJ tracker
    typedef enum logic [2:0] {
        EP_IDLE = 3'b001,
        EP_PICT = 3'b010,
        EP_ZWJ  = 3'b100
    } t_emoji;

    // Classified code point, as queued between front and back
    typedef struct packed {
        t_cls cls;
        t_cj  cj;
        logic pict;
        logic sot;
        logic is_ctl;   // CR, LF or control
        logic is_join;  // extend, ZWJ or spacing mark
    } t_cp;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

/* design/gcb_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gcb_in_if;
    logic                      valid;
    logic                      ready;
    logic [gcb_pkg::CLS_W-1:0] boundary_class;
    logic [gcb_pkg::CJ_W-1:0]  conjunct_kind;
    logic                      is_pictograph;
    logic                      start_of_text;

    modport source (
        output valid, boundary_class, conjunct_kind, is_pictograph, start_of_text,
        input  ready
    );
    modport sink (
        input  valid, boundary_class, conjunct_kind, is_pictograph, start_of_text,
        output ready
    );
endinterface

`default_nettype wire

/* design/gcb_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gcb_out_if;
    logic valid;
    logic ready;
    logic break_before;

    modport source (
        output valid, break_before,
        input  ready
    );
    modport sink (
        input  valid, break_before,
        output ready
    );
endinterface

`default_nettype wire

/* design/gcb_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcb_front (
    gcb_in_if.sink                i_in,
    input  wire gcb_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output gcb_pkg::t_cp          o_push_data
);

    gcb_pkg::t_cls w_cls;

    // Accept whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // Fold unused class codes to OTHER
    always_comb begin
        if (i_in.boundary_class > gcb_pkg::CLS_W'(gcb_pkg::CLS_LVT)) begin
            w_cls = gcb_pkg::CLS_OTHER;
        end else begin
            w_cls = gcb_pkg::t_cls'(i_in.boundary_class);
        end
    end

    // Pre-decode the class groups the back end tests every item
    always_comb begin
        o_push_data.cls     = w_cls;
        o_push_data.cj      = gcb_pkg::t_cj'(i_in.conjunct_kind);
        o_push_data.pict    = i_in.is_pictograph;
        o_push_data.sot     = i_in.start_of_text;
        o_push_data.is_ctl  = (w_cls == gcb_pkg::CLS_CR) || (w_cls == gcb_pkg::CLS_LF) ||
                              (w_cls == gcb_pkg::CLS_CONTROL);
        o_push_data.is_join = (w_cls == gcb_pkg::CLS_EXTEND) || (w_cls == gcb_pkg::CLS_ZWJ) ||
                              (w_cls == gcb_pkg::CLS_SPACING);
    end

endmodule

`default_nettype wire

/* design/gcb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcb_queue #(
    parameter int DEPTH = gcb_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gcb_pkg::t_cp  i_push_data,
    input  wire logic          i_pop,
    output gcb_pkg::t_cp       o_head,
    output gcb_pkg::t_q_stat   o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    gcb_pkg::t_cp    r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer wrap for depths that need not be a power of two
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/gcb_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcb_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gcb_pkg::t_cp     i_head,
    input  wire gcb_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    gcb_out_if.source             o_out
);

    gcb_pkg::t_cls   r_prior_cls;
    logic            r_prior_valid;
    logic            r_odd_ri;
    gcb_pkg::t_emoji r_emoji, n_emoji;
    logic            r_linker;
    logic            r_out_valid;
    logic            r_brk;

    gcb_pkg::t_cls   w_p, w_c;
    logic            w_pv, w_odd, w_linker, w_p_ctl, w_brk, w_rule;
    gcb_pkg::t_emoji w_emoji;

    // Step one item when the queue holds one and the output slot is free or being emptied
    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_out.ready);

    assign o_out.valid        = r_out_valid;
    assign o_out.break_before = r_brk;

    // Start of text clears the state before judging
    always_comb begin
        w_c      = i_head.cls;
        w_pv     = r_prior_valid && !i_head.sot;
        w_odd    = r_odd_ri && !i_head.sot;
        w_linker = r_linker && !i_head.sot;
        w_emoji  = i_head.sot ? gcb_pkg::EP_IDLE : r_emoji;
        w_p      = i_head.sot ? gcb_pkg::CLS_OTHER : r_prior_cls;
        w_p_ctl  = (w_p == gcb_pkg::CLS_CR) || (w_p == gcb_pkg::CLS_LF) ||
                   (w_p == gcb_pkg::CLS_CONTROL);
    end

    // Boundary rules, first match decides
    always_comb begin
        if (w_p == gcb_pkg::CLS_CR && w_c == gcb_pkg::CLS_LF) begin
            w_rule = 1'b0;
        end else if (w_p_ctl || i_head.is_ctl) begin
            w_rule = 1'b1;
        end else if (w_p == gcb_pkg::CLS_L &&
                     (w_c == gcb_pkg::CLS_L || w_c == gcb_pkg::CLS_V ||
                      w_c == gcb_pkg::CLS_LV || w_c == gcb_pkg::CLS_LVT)) begin
            w_rule = 1'b0;
        end else if ((w_p == gcb_pkg::CLS_LV || w_p == gcb_pkg::CLS_V) &&
                     (w_c == gcb_pkg::CLS_V || w_c == gcb_pkg::CLS_T)) begin
            w_rule = 1'b0;
        end else if ((w_p == gcb_pkg::CLS_LVT || w_p == gcb_pkg::CLS_T) &&
                     w_c == gcb_pkg::CLS_T) begin
            w_rule = 1'b0;
        end else if (i_head.is_join || w_p == gcb_pkg::CLS_PREPEND) begin
            w_rule = 1'b0;
        end else if (i_head.cj == gcb_pkg::CJ_CONSONANT && w_linker) begin
            w_rule = 1'b0;
        end else if (i_head.pict && w_emoji == gcb_pkg::EP_ZWJ) begin
            w_rule = 1'b0;
        end else if (w_p == gcb_pkg::CLS_RI && w_c == gcb_pkg::CLS_RI && w_odd) begin
            w_rule = 1'b0;
        end else begin
            w_rule = 1'b1;
        end
        w_brk = !w_pv || w_rule;
    end

    // Emoji tracker
    always_comb begin
        if (i_head.pict) begin
            n_emoji = gcb_pkg::EP_PICT;
        end else begin
            unique case (w_emoji)
                gcb_pkg::EP_PICT: begin
                    if (w_c == gcb_pkg::CLS_ZWJ) begin
                        n_emoji = gcb_pkg::EP_ZWJ;
                    end else if (w_c == gcb_pkg::CLS_EXTEND) begin
                        n_emoji = gcb_pkg::EP_PICT;
                    end else begin
                        n_emoji = gcb_pkg::EP_IDLE;
                    end
                end
                default: n_emoji = gcb_pkg::EP_IDLE;
            endcase
        end
    end

    // Cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_cls   <= gcb_pkg::CLS_OTHER;
            r_prior_valid <= 1'b0;
            r_odd_ri      <= 1'b0;
            r_emoji       <= gcb_pkg::EP_IDLE;
            r_linker      <= 1'b0;
        end else if (o_pop) begin
            r_prior_cls   <= w_c;
            r_prior_valid <= 1'b1;
            r_odd_ri      <= (w_c == gcb_pkg::CLS_RI) &&
                             !(w_pv && w_p == gcb_pkg::CLS_RI && w_odd);
            r_emoji       <= n_emoji;
            r_linker      <= (i_head.cj == gcb_pkg::CJ_LINKER) ||
                             (w_linker && i_head.cj == gcb_pkg::CJ_EXTEND);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_brk <= w_brk;
        end
    end

endmodule

`default_nettype wire

/* design/grapheme_cluster_break_detector_top.sv */
// An accepted item is held in the queue, then its result is registered in the output slot.
// Throughput: one item per cycle while o_out.ready is not held low; state updates on each pop.
// A short queue sits between front and back; on an output stall it fills, then input ready drops.
// Reset: synchronous, active low; clears cluster state, empties the queue, drops o_out.valid.
`timescale 1ns / 1ps
`default_nettype none

module grapheme_cluster_break_detector_top #(
    parameter int QUEUE_DEPTH = gcb_pkg::QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gcb_in_if.sink     i_in,
    gcb_out_if.source  o_out
);

    logic             w_push;
    logic             w_pop;
    gcb_pkg::t_cp     w_push_data;
    gcb_pkg::t_cp     w_head;
    gcb_pkg::t_q_stat w_q_stat;

    // Classify incoming items
    gcb_front u_front (
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue
    gcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // Rule evaluation and state
    gcb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef ASSERT_OFF
    // A start-of-text item always reports a boundary
    a_sot_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_head.sot |=> o_out.valid && o_out.break_before)
        else $error("start-of-text item did not report a boundary");

    // Back end never overwrites a result that is still waiting
    a_pop_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !o_out.valid || o_out.ready)
        else $error("item stepped while output slot held");

    // A pushed item with no pop leaves the queue non-empty
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> !w_q_stat.empty)
        else $error("queue empty after push");
`endif

endmodule

`default_nettype wire

/* dv/grapheme_cluster_break_detector_top_test.sv */
`timescale 1ns / 1ps

module grapheme_cluster_break_detector_top_test;

    // Tracks cluster state and queues the boundary flag due for each accepted item
    class boundary_tracker;
        gcb_pkg::t_cls   prev_cls;
        bit              have_prev;
        bit              odd_ri_run;
        gcb_pkg::t_emoji emoji_state;
        bit              linker_run;
        bit              pending_breaks[$];
        int              mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            prev_cls     = gcb_pkg::CLS_OTHER;
            have_prev    = 1'b0;
            odd_ri_run   = 1'b0;
            emoji_state  = gcb_pkg::EP_IDLE;
            linker_run   = 1'b0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Judge one code point, then advance the cluster state
        function void note_code_point(logic [gcb_pkg::CLS_W-1:0] raw_cls,
                                      logic [gcb_pkg::CJ_W-1:0] cj, bit pict, bit sot);
            gcb_pkg::t_cls c;
            bit   brk;
            bit   prev_ctl;
            bit   cur_ctl;
            bit   follows_ri;
            // codes past LVT count as other
            c = (raw_cls > gcb_pkg::CLS_LVT) ? gcb_pkg::CLS_OTHER : gcb_pkg::t_cls'(raw_cls);
            if (sot) clear();
            prev_ctl = (prev_cls == gcb_pkg::CLS_CR) || (prev_cls == gcb_pkg::CLS_LF) ||
                       (prev_cls == gcb_pkg::CLS_CONTROL);
            cur_ctl  = (c == gcb_pkg::CLS_CR) || (c == gcb_pkg::CLS_LF) ||
                       (c == gcb_pkg::CLS_CONTROL);

            // rules in priority order, first match wins
            if (!have_prev)
                brk = 1'b1;
            else if (prev_cls == gcb_pkg::CLS_CR && c == gcb_pkg::CLS_LF)
                brk = 1'b0;
            else if (prev_ctl || cur_ctl)
                brk = 1'b1;
            else if (prev_cls == gcb_pkg::CLS_L &&
                     (c == gcb_pkg::CLS_L || c == gcb_pkg::CLS_V ||
                      c == gcb_pkg::CLS_LV || c == gcb_pkg::CLS_LVT))
                brk = 1'b0;
            else if ((prev_cls == gcb_pkg::CLS_LV || prev_cls == gcb_pkg::CLS_V) &&
                     (c == gcb_pkg::CLS_V || c == gcb_pkg::CLS_T))
                brk = 1'b0;
            else if ((prev_cls == gcb_pkg::CLS_LVT || prev_cls == gcb_pkg::CLS_T) &&
                     c == gcb_pkg::CLS_T)
                brk = 1'b0;
            else if (c == gcb_pkg::CLS_EXTEND || c == gcb_pkg::CLS_ZWJ ||
                     c == gcb_pkg::CLS_SPACING)
                brk = 1'b0;
            else if (prev_cls == gcb_pkg::CLS_PREPEND)
                brk = 1'b0;
            else if (cj == gcb_pkg::CJ_CONSONANT && linker_run)
                brk = 1'b0;
            else if (pict && emoji_state == gcb_pkg::EP_ZWJ)
                brk = 1'b0;
            else if (prev_cls == gcb_pkg::CLS_RI && c == gcb_pkg::CLS_RI && odd_ri_run)
                brk = 1'b0;
            else
                brk = 1'b1;

            // regional indicator pairing
            follows_ri = have_prev && prev_cls == gcb_pkg::CLS_RI;
            odd_ri_run = (c == gcb_pkg::CLS_RI) && !(follows_ri && odd_ri_run);

            // pictograph Extend* ZWJ tracking
            if (pict)
                emoji_state = gcb_pkg::EP_PICT;
            else if (emoji_state == gcb_pkg::EP_PICT && c == gcb_pkg::CLS_ZWJ)
                emoji_state = gcb_pkg::EP_ZWJ;
            else if (!(emoji_state == gcb_pkg::EP_PICT && c == gcb_pkg::CLS_EXTEND))
                emoji_state = gcb_pkg::EP_IDLE;

            linker_run   = (cj == gcb_pkg::CJ_LINKER) ||
                           (linker_run && cj == gcb_pkg::CJ_EXTEND);
            prev_cls     = c;
            have_prev    = 1'b1;
            pending_breaks.push_back(brk);
        endfunction

        task check_break_before(logic got);
            bit want;
            if (pending_breaks.size() == 0) begin
                report($sformatf("result %b with no item outstanding", got));
                return;
            end
            want = pending_breaks.pop_front();
            if (got !== want)
                report($sformatf("break_before %b, expected %b", got, want));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    gcb_in_if  in_if ();
    gcb_out_if out_if ();

    grapheme_cluster_break_detector_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    boundary_tracker tracker = new();

    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Generous overall limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Offer one item and hold it until accepted; maybe idle afterwards
    task automatic send_cp(logic [gcb_pkg::CLS_W-1:0] cls, logic [gcb_pkg::CJ_W-1:0] cj,
                           bit pict, bit sot);
        in_if.valid          <= 1'b1;
        in_if.boundary_class <= cls;
        in_if.conjunct_kind  <= cj;
        in_if.is_pictograph  <= pict;
        in_if.start_of_text  <= sot;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_code_point(cls, cj, pict, sot);
        items_sent++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_noise();
        send_cp(gcb_pkg::CLS_W'($urandom_range(15)), gcb_pkg::CJ_W'($urandom_range(3)),
                1'($urandom_range(1)), $urandom_range(39) == 0);
    endtask

    // One well-formed sequence with random content, or some noise
    task automatic send_random_run();
        int kind;
        int n;
        kind = $urandom_range(11);
        case (kind)
            0: begin
                // pictograph, extends, ZWJ, then usually another pictograph
                send_cp(gcb_pkg::CLS_W'($urandom_range(15)), gcb_pkg::CJ_NONE, 1'b1, 1'b0);
                repeat ($urandom_range(0, 2))
                    send_cp(gcb_pkg::CLS_EXTEND, gcb_pkg::CJ_W'($urandom_range(3)),
                            1'b0, 1'b0);
                send_cp(gcb_pkg::CLS_ZWJ, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
                send_cp(gcb_pkg::CLS_W'($urandom_range(15)), gcb_pkg::CJ_NONE,
                        $urandom_range(3) != 0, 1'b0);
            end
            1: begin
                // regional indicator run
                n = $urandom_range(1, 5);
                repeat (n) send_cp(gcb_pkg::CLS_RI, gcb_pkg::CJ_NONE,
                                   1'($urandom_range(1)), 1'b0);
            end
            2: begin
                // Hangul jamo and syllables
                n = $urandom_range(2, 5);
                repeat (n) send_cp(gcb_pkg::CLS_W'(gcb_pkg::CLS_L + $urandom_range(4)),
                                   gcb_pkg::CJ_NONE, 1'b0, 1'b0);
            end
            3: begin
                // consonant, linker, extends, consonant
                send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_CONSONANT, 1'b0, 1'b0);
                send_cp($urandom_range(1) ? gcb_pkg::CLS_EXTEND : gcb_pkg::CLS_OTHER,
                        gcb_pkg::CJ_LINKER, 1'b0, 1'b0);
                repeat ($urandom_range(0, 2))
                    send_cp(gcb_pkg::CLS_EXTEND, gcb_pkg::CJ_EXTEND, 1'b0, 1'b0);
                send_cp(gcb_pkg::CLS_W'($urandom_range(1) ? gcb_pkg::CLS_OTHER :
                                        $urandom_range(15)),
                        gcb_pkg::CJ_CONSONANT, 1'b0, 1'b0);
            end
            4: begin
                // line ends and controls
                send_cp(gcb_pkg::CLS_CR, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
                if ($urandom_range(3) != 0)
                    send_cp(gcb_pkg::CLS_LF, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
                else
                    send_noise();
            end
            5: begin
                send_cp(gcb_pkg::CLS_PREPEND, gcb_pkg::CJ_W'($urandom_range(3)), 1'b0, 1'b0);
                send_noise();
            end
            6: begin
                // base followed by extend, ZWJ or spacing marks, or a CR
                send_cp(gcb_pkg::CLS_W'($urandom_range(15)), gcb_pkg::CJ_W'($urandom_range(3)),
                        1'b0, 1'b0);
                n = $urandom_range(1, 3);
                repeat (n) send_cp(gcb_pkg::CLS_W'(gcb_pkg::CLS_EXTEND +
                                                   4 * $urandom_range(1) -
                                                   3 * $urandom_range(1) * $urandom_range(1)),
                                   gcb_pkg::CJ_W'($urandom_range(3)), 1'b0, 1'b0);
            end
            7: begin
                send_cp(gcb_pkg::CLS_W'($urandom_range(15)), gcb_pkg::CJ_W'($urandom_range(3)),
                        1'($urandom_range(1)), 1'b1);
            end
            default: begin
                send_noise();
            end
        endcase
    endtask

    // Result side: check accepted results, drive ready
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                tracker.check_break_before(out_if.break_before);
            if (hold_off_req > 0) begin
                hold_off_req--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus
    initial begin
        int target;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.boundary_class <= '0;
        in_if.conjunct_kind  <= '0;
        in_if.is_pictograph  <= 1'b0;
        in_if.start_of_text  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first item, line ends and controls
        send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_CR, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_LF, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_CONTROL, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        // Hangul sequences
        send_cp(gcb_pkg::CLS_L, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_V, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_T, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_LV, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_T, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_LVT, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_T, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_L, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_LVT, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        // prepend, then unused class 14 as a linker, extend, consonant
        send_cp(gcb_pkg::CLS_PREPEND, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(4'd14, gcb_pkg::CJ_LINKER, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_EXTEND, gcb_pkg::CJ_EXTEND, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_CONSONANT, 1'b0, 1'b0);
        // pictograph Extend ZWJ pictograph
        send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_NONE, 1'b1, 1'b0);
        send_cp(gcb_pkg::CLS_EXTEND, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_ZWJ, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_OTHER, gcb_pkg::CJ_NONE, 1'b1, 1'b0);
        send_cp(gcb_pkg::CLS_SPACING, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        // three regional indicators: pair, then a break
        send_cp(gcb_pkg::CLS_RI, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_RI, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        send_cp(gcb_pkg::CLS_RI, gcb_pkg::CJ_NONE, 1'b0, 1'b0);
        // restart with every field at its top value
        send_cp(4'd15, gcb_pkg::CJ_EXTEND, 1'b1, 1'b1);

        // random phases; the first opens with a long receiver hold-off
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    hold_off_req = 60;
                end
                1: begin
                    send_idle_pct = 48; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct = 10; recv_stall_pct = 10;
                end
            endcase
            target = items_sent + 375;
            while (items_sent < target) send_random_run();
        end
        in_if.valid <= 1'b0;

        // drain and let the pipeline settle
        while (tracker.pending_breaks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.pending_breaks.size() != 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.pending_breaks.size()));
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
